### hdl/tfbs_pkg.sv
// ----------------------------------------------------------------------------
// tfbs_pkg
// Marker bytes, escape codes and slot layout shared by the TLV frame stuffer.
// ----------------------------------------------------------------------------
package tfbs_pkg;

   localparam logic [7:0] MARK_ESC   = 8'hfa;
   localparam logic [7:0] MARK_START = 8'hfb;
   localparam logic [7:0] MARK_END   = 8'hfc;
   localparam logic [7:0] MARK_X1    = 8'hff;
   localparam logic [7:0] MARK_X2    = 8'haa;

   localparam logic [7:0] CODE_NONE  = 8'h00;
   localparam logic [7:0] CODE_ESC   = 8'h01;
   localparam logic [7:0] CODE_START = 8'h02;
   localparam logic [7:0] CODE_END   = 8'h03;
   localparam logic [7:0] CODE_X1    = 8'h04;
   localparam logic [7:0] CODE_X2    = 8'h05;

   localparam logic FUNC_BEGIN   = 1'b0;
   localparam logic FUNC_PAYLOAD = 1'b1;

   // Slot layout of one run: start, tag or data, length low, length high,
   // sum, end.
   localparam int NUM_SLOTS  = 6;
   localparam int SLOT_W     = $clog2(NUM_SLOTS);
   localparam int SLOT_START = 0;
   localparam int SLOT_TAG   = 1;
   localparam int SLOT_LEN_L = 2;
   localparam int SLOT_LEN_H = 3;
   localparam int SLOT_SUM   = 4;
   localparam int SLOT_END   = 5;

   typedef logic [NUM_SLOTS-1:0] slot_vec_type;
   typedef logic [7:0]           byte_type;

   function automatic byte_type esc_code(input byte_type b);
      byte_type c;
      unique case (b)
         MARK_ESC:   c = CODE_ESC;
         MARK_START: c = CODE_START;
         MARK_END:   c = CODE_END;
         MARK_X1:    c = CODE_X1;
         MARK_X2:    c = CODE_X2;
         default:    c = CODE_NONE;
      endcase
      return c;
   endfunction

endpackage

### hdl/tlv_frame_byte_stuffer_top.sv
// ----------------------------------------------------------------------------
// tlv_frame_byte_stuffer_top
// Builds TLV frames, with optional markers and escaping, one byte per beat.
//
// Input channel req_*: a begin beat (func 0) carries tag and frame length, a
// payload beat (func 1) carries one data byte. Output channel rsp_*: one
// encoded byte per beat, with last_of_run on the final byte caused by an
// input beat and frame_done on the final byte of a frame. csr_*: one-bit
// stuffing enable, always ready; to be written only while the block is idle,
// not enforced by the block. An accepted beat is expanded into a six-slot
// run register; its first byte appears on rsp_* in the next cycle. The run
// drains at one byte per cycle while rsp_ready is high, two bytes for an
// escaped slot, so an input beat yields 1 to 7 bytes (1 or 2 for most
// payload beats). req_ready is high while the run register is empty or its
// last byte is being taken, so back-to-back beats give a gapless output
// stream. A payload beat with no open frame is taken and yields nothing.
// When the receiver stalls, the current byte holds and req_ready drops.
// Reset empties the run register, closes any frame and enables stuffing.
// ----------------------------------------------------------------------------
module tlv_frame_byte_stuffer_top
   import tfbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [7:0]  req_tag,
   input  logic [15:0] req_frame_length,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_run,
   output logic        rsp_frame_done,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_stuffing_enable
);

   logic         stuff_ff;
   logic         open_ff,   open_in;
   logic [15:0]  remain_ff, remain_in;
   logic [7:0]   sum_ff,    sum_in;

   slot_vec_type vld_ff,    vld_in;
   slot_vec_type esc_ff,    esc_in;
   byte_type     slot_ff    [NUM_SLOTS];
   byte_type     slot_in    [NUM_SLOTS];
   logic         close_ff,  close_in;
   logic         phase_ff,  phase_in;

   logic              req_fire;
   logic              rsp_fire;
   logic [SLOT_W-1:0] cur;
   logic              last_slot;
   logic              last_byte;
   logic [7:0]        sum_pay;
   logic [15:0]       remain_dec;
   logic              trailer;

   assign csr_ready = 1'b1;

   always_comb begin
      cur = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (vld_ff[i]) cur = SLOT_W'(i);
      end
   end

   assign last_slot = ((vld_ff & (vld_ff - slot_vec_type'(1))) == '0);
   assign last_byte = last_slot && (!esc_ff[cur] || phase_ff);

   assign rsp_valid       = |vld_ff;
   assign rsp_fire        = rsp_valid && rsp_ready;
   assign req_ready       = !rsp_valid || (rsp_ready && last_byte);
   assign req_fire        = req_valid && req_ready;
   assign rsp_last_of_run = last_byte;
   assign rsp_frame_done  = last_byte && close_ff;

   always_comb begin
      if (esc_ff[cur] && !phase_ff) begin
         rsp_out_byte = MARK_ESC;
      end else if (esc_ff[cur]) begin
         rsp_out_byte = esc_code(slot_ff[cur]);
      end else begin
         rsp_out_byte = slot_ff[cur];
      end
   end

   assign sum_pay    = sum_ff + req_data_byte;
   assign remain_dec = remain_ff - 16'd1;
   assign trailer    = (req_func == FUNC_BEGIN) ? (req_frame_length == '0)
                                                : (remain_dec == '0);

   always_comb begin
      open_in   = open_ff;
      remain_in = remain_ff;
      sum_in    = sum_ff;
      vld_in    = vld_ff;
      esc_in    = esc_ff;
      close_in  = close_ff;
      phase_in  = phase_ff;
      for (int i = 0; i < NUM_SLOTS; i++) slot_in[i] = slot_ff[i];

      if (rsp_fire) begin
         if (esc_ff[cur] && !phase_ff) begin
            phase_in = 1'b1;
         end else begin
            phase_in    = 1'b0;
            vld_in[cur] = 1'b0;
         end
      end

      if (req_fire) begin
         slot_in[SLOT_START] = MARK_START;
         slot_in[SLOT_LEN_L] = req_frame_length[7:0];
         slot_in[SLOT_LEN_H] = req_frame_length[15:8];
         slot_in[SLOT_END]   = MARK_END;
         esc_in              = '0;
         phase_in            = 1'b0;
         close_in            = trailer;
         vld_in              = '0;
         if (req_func == FUNC_BEGIN) begin
            slot_in[SLOT_TAG]   = req_tag;
            slot_in[SLOT_SUM]   = 8'h00;
            vld_in[SLOT_START]  = stuff_ff;
            vld_in[SLOT_TAG]    = 1'b1;
            vld_in[SLOT_LEN_L]  = 1'b1;
            vld_in[SLOT_LEN_H]  = 1'b1;
            vld_in[SLOT_SUM]    = trailer;
            vld_in[SLOT_END]    = trailer && stuff_ff;
            open_in             = !trailer;
            remain_in           = req_frame_length;
            sum_in              = 8'h00;
         end else if (open_ff) begin
            slot_in[SLOT_TAG]   = req_data_byte;
            slot_in[SLOT_SUM]   = sum_pay;
            vld_in[SLOT_TAG]    = 1'b1;
            vld_in[SLOT_SUM]    = trailer;
            vld_in[SLOT_END]    = trailer && stuff_ff;
            open_in             = !trailer;
            remain_in           = trailer ? 16'd0 : remain_dec;
            sum_in              = sum_pay;
         end
         esc_in[SLOT_TAG]   = stuff_ff && (esc_code(slot_in[SLOT_TAG]) != CODE_NONE);
         esc_in[SLOT_LEN_L] = stuff_ff && (esc_code(slot_in[SLOT_LEN_L]) != CODE_NONE);
         esc_in[SLOT_LEN_H] = stuff_ff && (esc_code(slot_in[SLOT_LEN_H]) != CODE_NONE);
         esc_in[SLOT_SUM]   = stuff_ff && (esc_code(slot_in[SLOT_SUM]) != CODE_NONE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stuff_ff  <= 1'b1;
         open_ff   <= 1'b0;
         remain_ff <= '0;
         sum_ff    <= '0;
         vld_ff    <= '0;
         phase_ff  <= 1'b0;
         close_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) stuff_ff <= csr_stuffing_enable;
         open_ff   <= open_in;
         remain_ff <= remain_in;
         sum_ff    <= sum_in;
         vld_ff    <= vld_in;
         phase_ff  <= phase_in;
         close_ff  <= close_in;
      end
   end

   always_ff @(posedge clock) begin
      esc_ff <= esc_in;
      for (int i = 0; i < NUM_SLOTS; i++) slot_ff[i] <= slot_in[i];
   end

endmodule

### hdl/tfbs_checker.sv
// ----------------------------------------------------------------------------
// tfbs_checker
// Port-level checks for the TLV frame stuffer, bound to the top level.
// ----------------------------------------------------------------------------
module tfbs_checker
   import tfbs_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_of_run,
   input logic       rsp_frame_done
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_byte) && $stable(rsp_last_of_run)
                                  && $stable(rsp_frame_done))
      else $error("rsp payload changed while stalled");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_last_of_run)
      else $error("frame end not at end of run");

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("req taken while output stalled");

endmodule

bind tlv_frame_byte_stuffer_top tfbs_checker u_tfbs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_last_of_run (rsp_last_of_run),
   .rsp_frame_done  (rsp_frame_done)
);

### test/tlv_frame_byte_stuffer_top_tb.sv
// ----------------------------------------------------------------------------
// tlv_frame_byte_stuffer_top_tb
// Self-checking bench for the TLV frame stuffer. Directed frames cover the
// marker and escape values, zero-length frames, stray payload and restarts,
// with stuffing on and off. Random frames then follow, with bursty input, a
// stalling receiver and one long output hold. Every output beat is checked
// against a byte-level prediction of the encoded stream.
// ----------------------------------------------------------------------------
module tlv_frame_byte_stuffer_top_tb;
   import tfbs_pkg::*;

   localparam int ITEM_TARGET  = 300;
   localparam int LONG_HOLD    = 300;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 12;

   class frame_scoreboard;
      typedef struct packed {
         byte_type data;
         logic     last;
         logic     done;
      } coded_byte_type;

      coded_byte_type expected_bytes[$];
      logic          stuffing_on;
      logic          frame_is_open;
      logic [15:0]   remaining;
      byte_type      running_total;
      int            errors;

      function new();
         stuffing_on   = 1'b1;
         frame_is_open = 1'b0;
         remaining     = '0;
         running_total = '0;
         errors        = 0;
      endfunction

      function void set_stuffing(input logic en);
         stuffing_on = en;
      endfunction

      function void push_raw(input byte_type b);
         coded_byte_type cb;
         cb.data = b;
         cb.last = 1'b0;
         cb.done = 1'b0;
         expected_bytes.push_back(cb);
      endfunction

      function void push_coded(input byte_type b);
         byte_type code;
         code = CODE_NONE;
         if (stuffing_on) begin
            case (b)
               MARK_ESC:   code = CODE_ESC;
               MARK_START: code = CODE_START;
               MARK_END:   code = CODE_END;
               MARK_X1:    code = CODE_X1;
               MARK_X2:    code = CODE_X2;
               default:    code = CODE_NONE;
            endcase
         end
         if (code != CODE_NONE) begin
            push_raw(MARK_ESC);
            push_raw(code);
         end else begin
            push_raw(b);
         end
      endfunction

      function void close_frame();
         push_coded(running_total);
         if (stuffing_on)
            push_raw(MARK_END);
         expected_bytes[expected_bytes.size()-1].done = 1'b1;
         frame_is_open = 1'b0;
         remaining     = '0;
      endfunction

      function void note_beat(input logic func, input byte_type tag,
                              input logic [15:0] len, input byte_type data);
         int first;
         first = expected_bytes.size();
         if (func == FUNC_BEGIN) begin
            running_total = '0;
            frame_is_open = 1'b1;
            remaining     = len;
            if (stuffing_on)
               push_raw(MARK_START);
            push_coded(tag);
            push_coded(len[7:0]);
            push_coded(len[15:8]);
            if (len == 16'd0)
               close_frame();
         end else if (frame_is_open) begin
            push_coded(data);
            running_total = running_total + data;
            remaining     = remaining - 16'd1;
            if (remaining == 16'd0)
               close_frame();
         end
         if (expected_bytes.size() > first)
            expected_bytes[expected_bytes.size()-1].last = 1'b1;
      endfunction

      function void check_byte(input byte_type data, input logic last,
                               input logic done);
         coded_byte_type cb;
         if (expected_bytes.size() == 0) begin
            $error("rsp beat with nothing expected: out_byte %02h", data);
            errors++;
            return;
         end
         cb = expected_bytes.pop_front();
         if (data !== cb.data) begin
            $error("out_byte: expected %02h, actual %02h", cb.data, data);
            errors++;
         end
         if (last !== cb.last) begin
            $error("last_of_run: expected %0b, actual %0b", cb.last, last);
            errors++;
         end
         if (done !== cb.done) begin
            $error("frame_done: expected %0b, actual %0b", cb.done, done);
            errors++;
         end
      endfunction
   endclass

   logic        clock               = 1'b0;
   logic        reset               = 1'b1;
   logic        req_valid           = 1'b0;
   logic        req_ready;
   logic        req_func            = FUNC_BEGIN;
   logic [7:0]  req_tag             = '0;
   logic [15:0] req_frame_length    = '0;
   logic [7:0]  req_data_byte       = '0;
   logic        rsp_valid;
   logic        rsp_ready           = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_of_run;
   logic        rsp_frame_done;
   logic        csr_valid           = 1'b0;
   logic        csr_ready;
   logic        csr_stuffing_enable = 1'b1;

   frame_scoreboard sb;
   int  items_sent;
   int  burst_left;
   int  idle_cycles;
   bit  gapless;
   bit  long_hold_req;
   bit  rsp_holding;

   tlv_frame_byte_stuffer_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_tag            (req_tag),
      .req_frame_length   (req_frame_length),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_frame_done     (rsp_frame_done),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_stuffing_enable(csr_stuffing_enable)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_byte(rsp_out_byte, rsp_last_of_run, rsp_frame_done);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin : rsp_stall_gen
      int mode;
      int span;
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_holding   = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_holding = 1'b0;
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(4, 40);
         repeat (span) begin
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= ($urandom_range(0, 3) != 0);
               2:       rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   function automatic byte_type rand_byte();
      case ($urandom_range(0, 9))
         0:       return MARK_ESC;
         1:       return MARK_START;
         2:       return MARK_END;
         3:       return MARK_X1;
         4:       return MARK_X2;
         default: return byte_type'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [15:0] rand_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10)
         return 16'd0;
      else if (pick < 80)
         return 16'($urandom_range(1, 6));
      else if (pick < 95)
         return 16'($urandom_range(7, 40));
      else
         return 16'($urandom_range(0, 65535));
   endfunction

   task automatic pause(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic send_beat(input logic func, input byte_type tag,
                            input logic [15:0] len, input byte_type data);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (!gapless)
            pause($urandom_range(1, 10));
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_func         <= func;
      req_tag          <= tag;
      req_frame_length <= len;
      req_data_byte    <= data;
      do @(posedge clock); while (!req_ready);
      sb.note_beat(func, tag, len, data);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_stuffing(input logic en);
      csr_valid           <= 1'b1;
      csr_stuffing_enable <= en;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_stuffing(en);
   endtask

   task automatic send_frame(input logic [15:0] len, input int beats);
      send_beat(FUNC_BEGIN, rand_byte(), len, rand_byte());
      items_sent++;
      for (int i = 0; i < beats; i++) begin
         send_beat(FUNC_PAYLOAD, rand_byte(), 16'($urandom_range(0, 65535)),
                   rand_byte());
         items_sent++;
      end
   endtask

   task automatic random_frame();
      logic [15:0] len;
      int          beats;
      len   = rand_len();
      beats = (len > 40) ? $urandom_range(0, 12) : int'(len);
      if (len <= 40 && $urandom_range(0, 9) == 0)
         beats = $urandom_range(0, len);
      send_frame(len, beats);
      if ($urandom_range(0, 7) == 0)
         send_beat(FUNC_PAYLOAD, rand_byte(), 16'($urandom_range(0, 65535)),
                   rand_byte());
   endtask

   initial begin
      sb         = new();
      items_sent = 0;
      burst_left = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      write_stuffing(1'b1);
      send_beat(FUNC_BEGIN,   8'h00, 16'h0000, 8'h00);
      send_beat(FUNC_PAYLOAD, 8'h00, 16'h0000, 8'h55);
      send_beat(FUNC_BEGIN,   8'hff, 16'hffff, 8'hff);
      send_beat(FUNC_PAYLOAD, 8'hff, 16'hffff, 8'h00);
      send_beat(FUNC_BEGIN,   MARK_ESC, 16'hfcfb, 8'h00);
      send_beat(FUNC_BEGIN,   MARK_X2, 16'h0005, 8'h00);
      send_beat(FUNC_PAYLOAD, 8'h00, 16'h0000, MARK_ESC);
      send_beat(FUNC_PAYLOAD, 8'h00, 16'h0000, MARK_START);
      send_beat(FUNC_PAYLOAD, 8'h00, 16'h0000, MARK_END);
      send_beat(FUNC_PAYLOAD, 8'h00, 16'h0000, MARK_X1);
      send_beat(FUNC_PAYLOAD, 8'h00, 16'h0000, MARK_X2);
      send_beat(FUNC_BEGIN,   MARK_START, 16'h0001, 8'h00);
      send_beat(FUNC_PAYLOAD, 8'h00, 16'h0000, MARK_START);
      send_beat(FUNC_BEGIN,   8'h01, 16'h0002, 8'h00);
      send_beat(FUNC_PAYLOAD, 8'h00, 16'h0000, 8'h80);
      send_beat(FUNC_PAYLOAD, 8'h00, 16'h0000, 8'h7f);
      wait_idle();

      write_stuffing(1'b0);
      send_beat(FUNC_BEGIN,   MARK_ESC, 16'h0002, 8'h00);
      send_beat(FUNC_PAYLOAD, 8'h00, 16'h0000, MARK_X1);
      send_beat(FUNC_PAYLOAD, 8'h00, 16'h0000, MARK_START);
      send_beat(FUNC_BEGIN,   MARK_START, 16'h0000, 8'h00);
      send_beat(FUNC_PAYLOAD, 8'h00, 16'h0000, MARK_END);
      send_beat(FUNC_BEGIN,   MARK_X2, 16'hffff, 8'h00);
      send_beat(FUNC_PAYLOAD, 8'h00, 16'h0000, MARK_X2);
      wait_idle();

      items_sent = 0;
      for (int phase = 0; phase < 4; phase++) begin
         wait_idle();
         case (phase)
            0:       write_stuffing(1'b1);
            1:       write_stuffing(1'b0);
            2:       write_stuffing(1'b1);
            default: write_stuffing(1'($urandom_range(0, 1)));
         endcase
         if (phase == 1) begin
            long_hold_req = 1'b1;
            wait (rsp_holding);
            gapless = 1'b1;
            send_frame(16'd24, 24);
            gapless = 1'b0;
         end
         while (items_sent < (phase + 1) * ITEM_TARGET / 4) begin
            random_frame();
            if (phase == 2 && $urandom_range(0, 15) == 0) begin
               wait_idle();
               burst_left = 0;
            end
         end
      end
      wait_idle();

      if (sb.errors == 0 && sb.expected_bytes.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

### filelist.f
hdl/tfbs_pkg.sv
hdl/tlv_frame_byte_stuffer_top.sv
hdl/tfbs_checker.sv
test/tlv_frame_byte_stuffer_top_tb.sv
